// File: src/firsat_pkg.sv
// ----------------------------------------------------------------------------
// firsat_pkg
// Types, constants and arithmetic helpers of the saturating fixed-point FIR.
// ----------------------------------------------------------------------------
package firsat_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 4;
  localparam int NUM_COEFS     = 8;
  localparam int TAP_COUNT_DEF = 8;
  localparam int PROD_W        = SAMPLE_W + COEF_W;
  localparam int SUM_W         = SAMPLE_W + 1;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int DATA_W        = 32;
  localparam int CFG_ADDR_W    = $clog2(NUM_COEFS * 4);
  localparam int CFG_IDX_LSB   = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  localparam coef_t COEF_RESET [NUM_COEFS] = '{
    -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd1, 4'sd2, 4'sd3, 4'sd4
  };

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // clamp a value that carries one extra integer bit
  function automatic sample_t sat_sum(input logic signed [SUM_W-1:0] v);
    sample_t r;
    if (v[SUM_W-1] == v[SUM_W-2]) begin
      r = v[SAMPLE_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = SAT_MIN;
    end else begin
      r = SAT_MAX;
    end
    return r;
  endfunction

  function automatic sample_t sat_add(input sample_t a, input sample_t b);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    return sat_sum(s);
  endfunction

  // Q10.6 x Q3.1 -> 7 fraction bits, round half to even to 6, clamp to 16 bits
  function automatic sample_t tap_product(input sample_t s, input coef_t c);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] q;
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    sample_t                  r;
    p  = PROD_W'(s) * PROD_W'(c);
    q  = p >>> 1;
    if (p[0] && q[0]) begin
      q = q + PROD_W'(1);
    end
    hi = PROD_W'(SAT_MAX);
    lo = PROD_W'(SAT_MIN);
    if (q > hi) begin
      r = SAT_MAX;
    end else if (q < lo) begin
      r = SAT_MIN;
    end else begin
      r = q[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/firsat_front.sv
// ----------------------------------------------------------------------------
// firsat_front
// Takes input words, keeps the delay line and pushes the tap window.
// ----------------------------------------------------------------------------
module firsat_front #(
  parameter int TAP_COUNT = firsat_pkg::TAP_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  firsat_pkg::sample_t sample_i,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic                q_full_i,
  output logic                push_o,
  output firsat_pkg::sample_t win_o [TAP_COUNT]
);
  import firsat_pkg::*;

  localparam int LineDepth = TAP_COUNT - 1;

  sample_t delay_q [LineDepth];
  logic    accept;

  assign stall_o = q_full_i;
  assign accept  = valid_i && !q_full_i;
  assign push_o  = accept;

  always_comb begin
    win_o[0] = sample_i;
    for (int i = 1; i < TAP_COUNT; i++) begin
      win_o[i] = delay_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LineDepth; i++) begin
        delay_q[i] <= '0;
      end
    end else if (accept) begin
      delay_q[0] <= sample_i;
      for (int i = 1; i < LineDepth; i++) begin
        delay_q[i] <= delay_q[i-1];
      end
    end
  end

endmodule

// File: src/firsat_queue.sv
// ----------------------------------------------------------------------------
// firsat_queue
// Short FIFO of tap windows between the front and the back.
// ----------------------------------------------------------------------------
module firsat_queue #(
  parameter int TAP_COUNT = firsat_pkg::TAP_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  firsat_pkg::sample_t   win_i [TAP_COUNT],
  input  logic                  pop_i,
  output firsat_pkg::sample_t   win_o [TAP_COUNT],
  output firsat_pkg::q_status_t status_o
);
  import firsat_pkg::*;

  sample_t           mem_q [QUEUE_DEPTH][TAP_COUNT];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign status_o.count = cnt_q;
  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  assign win_o = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QPTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= win_i;
    end
  end

endmodule

// File: src/firsat_back.sv
// ----------------------------------------------------------------------------
// firsat_back
// Tap products, then one registered level per adder tree stage; the last
// level is the output register.
// ----------------------------------------------------------------------------
module firsat_back #(
  parameter int TAP_COUNT = firsat_pkg::TAP_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  firsat_pkg::sample_t win_i [TAP_COUNT],
  input  logic                q_empty_i,
  output logic                pop_o,
  input  firsat_pkg::coef_t   coef_i [firsat_pkg::NUM_COEFS],
  output firsat_pkg::sample_t data_o,
  output logic                valid_o,
  input  logic                stall_i
);
  import firsat_pkg::*;

  localparam int Levels = $clog2(TAP_COUNT);

  sample_t          stage_q [Levels+1][TAP_COUNT];
  logic [Levels:0]  vld_q;
  logic             en;

  // whole pipe holds while the output word waits
  assign en    = !(vld_q[Levels] && stall_i);
  assign pop_o = en && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Levels-1:0], !q_empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < TAP_COUNT; j++) begin
        stage_q[0][j] <= tap_product(win_i[j], coef_i[j]);
      end
    end
  end

  for (genvar l = 1; l <= Levels; l++) begin : g_lvl
    localparam int N = (TAP_COUNT + (1 << (l - 1)) - 1) >> (l - 1);
    localparam int H = N / 2;
    for (genvar j = 0; j < TAP_COUNT; j++) begin : g_term
      if (j < H) begin : g_add
        always_ff @(posedge clk_i) begin
          if (en) begin
            stage_q[l][j] <= sat_add(stage_q[l-1][j], stage_q[l-1][j+N-H]);
          end
        end
      end else begin : g_pass
        // unpaired terms carry over unchanged, such as the middle term of an odd count
        always_ff @(posedge clk_i) begin
          if (en) begin
            stage_q[l][j] <= stage_q[l-1][j];
          end
        end
      end
    end
  end

  assign data_o  = stage_q[Levels][0];
  assign valid_o = vld_q[Levels];

endmodule

// File: src/fir_filter_saturating_fixed_point_core.sv
// ----------------------------------------------------------------------------
// fir_filter_saturating_fixed_point_core
// Eight-tap saturating Q10.6 FIR with programmable Q3.1 coefficients.
//
//   channel   | direction | handshake                     | payload
//   ----------+-----------+-------------------------------+---------------------
//   sample_in | in        | sample_in_valid_i / _stall_o  | sample_in_i [15:0]
//   filtered  | out       | filtered_out_valid_o/_stall_i | filtered_out_o [15:0]
//   config    | in        | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// One sample per cycle sustained while filtered_out_stall_i stays low; a
// sample passes the queue, the product register and one register per tree level.
// Reset zeroes the delay line and loads the default coefficients.
// A stalled output word freezes the back pipe; the two-entry window queue
// keeps taking samples until it fills, then sample_in_stall_o rises.
// ----------------------------------------------------------------------------
module fir_filter_saturating_fixed_point_core #(
  parameter int TAP_COUNT = firsat_pkg::TAP_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  firsat_pkg::sample_t                 sample_in_i,
  input  logic                                sample_in_valid_i,
  output logic                                sample_in_stall_o,
  output firsat_pkg::sample_t                 filtered_out_o,
  output logic                                filtered_out_valid_o,
  input  logic                                filtered_out_stall_i,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [firsat_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [firsat_pkg::DATA_W-1:0]       pwdata,
  output logic [firsat_pkg::DATA_W-1:0]       prdata,
  output logic                                pready
);
  import firsat_pkg::*;

  localparam int IdxW = CFG_ADDR_W - CFG_IDX_LSB;

  coef_t     coef_q [NUM_COEFS];
  logic [IdxW-1:0] cfg_idx;
  logic      cfg_wr;
  coef_t     rd_coef;

  sample_t   front_win [TAP_COUNT];
  sample_t   back_win  [TAP_COUNT];
  logic      push, pop;
  q_status_t q_status;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_IDX_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign rd_coef = coef_q[cfg_idx];
  assign prdata  = {{(DATA_W-COEF_W){rd_coef[COEF_W-1]}}, rd_coef};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_q[i] <= COEF_RESET[i];
      end
    end else if (cfg_wr) begin
      coef_q[cfg_idx] <= pwdata[COEF_W-1:0];
    end
  end

  // ---------------- datapath ----------------
  firsat_front #(.TAP_COUNT(TAP_COUNT)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_in_i),
    .valid_i  (sample_in_valid_i),
    .stall_o  (sample_in_stall_o),
    .q_full_i (q_status.full),
    .push_o   (push),
    .win_o    (front_win)
  );

  firsat_queue #(.TAP_COUNT(TAP_COUNT)) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .win_i    (front_win),
    .pop_i    (pop),
    .win_o    (back_win),
    .status_o (q_status)
  );

  firsat_back #(.TAP_COUNT(TAP_COUNT)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .win_i     (back_win),
    .q_empty_i (q_status.empty),
    .pop_o     (pop),
    .coef_i    (coef_q),
    .data_o    (filtered_out_o),
    .valid_o   (filtered_out_valid_o),
    .stall_i   (filtered_out_stall_i)
  );

`ifndef NO_ASSERTIONS
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("window queue over depth");

  a_no_pop_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filtered_out_valid_o && filtered_out_stall_i) |=>
      (q_status.count >= $past(q_status.count)))
    else $error("queue drained while output stalled");

  a_accept_fills_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_in_valid_i && !sample_in_stall_o) |=> !q_status.empty)
    else $error("accepted word missing from queue");
`endif

endmodule
